>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/core/iprt_pkg.sv
// ----------------------------------------------------------------------------
// iprt_pkg
// Types and constants of the IPv4 peer route table.
// ----------------------------------------------------------------------------
package iprt_pkg;

   localparam int ADDR_W     = 32;
   localparam int PEER_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 3;
   localparam int ROUTE_CNT_W = 7;
   localparam int BYTE_CNT_W = 17;
   localparam int LEN_W      = 16;

   localparam logic [BYTE_CNT_W-1:0] BYTE_CAP   = 17'd65536;
   localparam logic [BYTE_CNT_W-1:0] MAX_LEN    = 17'd65535;
   localparam logic [BYTE_CNT_W-1:0] MIN_HEADER = 17'd20;
   localparam logic [3:0]            IP_VERSION = 4'd4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_REGISTER   = 3'd0,
      OP_UNREGISTER = 3'd1,
      OP_LOOKUP     = 3'd2,
      OP_PACKET     = 3'd3,
      OP_PEER_GONE  = 3'd4,
      OP_COUNT      = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 3'd0,
      ST_NULL_PEER  = 3'd1,
      ST_HELD       = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_BAD_HEADER = 3'd4,
      ST_TOO_SHORT  = 3'd5,
      ST_FULL       = 3'd6
   } status_type;

   typedef struct packed {
      logic              good;
      status_type        status;
      logic [ADDR_W-1:0] dest;
   } hdr_result_type;

endpackage

>>> rtl/core/iprt_if.sv
// ----------------------------------------------------------------------------
// iprt_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface iprt_req_if import iprt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   address;
   logic [PEER_W-1:0]   peer_id;
   logic [BYTE_W-1:0]   packet_byte;
   logic                packet_last;

   modport source (output valid, opcode, address, peer_id, packet_byte, packet_last,
                   input ready);
   modport sink (input valid, opcode, address, peer_id, packet_byte, packet_last,
                 output ready);
endinterface

interface iprt_rsp_if import iprt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [PEER_W-1:0]      found_peer;
   logic [STATUS_W-1:0]    status;
   logic [ROUTE_CNT_W-1:0] route_count;

   modport source (output valid, ok, found_peer, status, route_count, input ready);
   modport sink (input valid, ok, found_peer, status, route_count, output ready);
endinterface

>>> rtl/core/iprt_ram.sv
// ----------------------------------------------------------------------------
// iprt_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module iprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/core/iprt_hdr_check.sv
// ----------------------------------------------------------------------------
// iprt_hdr_check
// Gathers IPv4 header fields from packet bytes and checks the header.
// ----------------------------------------------------------------------------
module iprt_hdr_check import iprt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_en,
   input  logic [BYTE_W-1:0]  byte_data,
   input  logic               byte_last,
   output hdr_result_type     result
);

   logic [BYTE_CNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]     first_ff, first_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ADDR_W-1:0]     dest_ff, dest_in;
   logic [5:0]            hdr_len;
   logic                  bad;

   always_comb begin
      first_in = first_ff;
      len_in   = len_ff;
      dest_in  = dest_ff;
      if (count_ff == 17'd0) begin
         first_in = byte_data;
      end else if (count_ff == 17'd2) begin
         len_in = {byte_data, len_ff[7:0]};
      end else if (count_ff == 17'd3) begin
         len_in = {len_ff[15:8], byte_data};
      end else if (count_ff >= 17'd16 && count_ff <= 17'd19) begin
         dest_in = {dest_ff[ADDR_W-9:0], byte_data};
      end
      count_in = (count_ff == BYTE_CAP) ? count_ff : count_ff + 17'd1;

      hdr_len = {first_in[3:0], 2'b00};
      bad = (first_in[7:4] != IP_VERSION) || ({11'd0, hdr_len} < MIN_HEADER) ||
            ({11'd0, hdr_len} > count_in) || (count_in > MAX_LEN) ||
            ({1'b0, len_in} != count_in);

      result.dest = dest_in;
      if (count_in < MIN_HEADER) begin
         result.good   = 1'b0;
         result.status = ST_TOO_SHORT;
      end else if (bad) begin
         result.good   = 1'b0;
         result.status = ST_BAD_HEADER;
      end else begin
         result.good   = 1'b1;
         result.status = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         len_ff   <= '0;
         dest_ff  <= '0;
      end else if (byte_en) begin
         // restart capture after the last byte
         if (byte_last) begin
            count_ff <= '0;
            first_ff <= '0;
            len_ff   <= '0;
            dest_ff  <= '0;
         end else begin
            count_ff <= count_in;
            first_ff <= first_in;
            len_ff   <= len_in;
            dest_ff  <= dest_in;
         end
      end
   end

endmodule

>>> rtl/core/ipv4_peer_route_table.sv
// ----------------------------------------------------------------------------
// ipv4_peer_route_table
// Exact-match IPv4 address to peer id table with peer liveness.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(TABLE_ENTRIES, PEER_IDS)
// addresses (256 by default) with req ready low. A packet byte that is not the
// last is taken every cycle. Every other item that touches the table walks
// all entries through the entry RAM read port, one entry per cycle; peer gone
// first writes the liveness RAM in a state of its own. Items with a null peer,
// a bad header or an unused opcode skip the walk and go straight to the result
// state. One item is in work at a time; a response waits in its output
// register while the next item is accepted.
`include "assert_macros.svh"

module ipv4_peer_route_table import iprt_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PEER_IDS      = 256
) (
   input  logic   clock,
   input  logic   reset,
   iprt_req_if.sink   req_ch,
   iprt_rsp_if.source rsp_ch
);

   localparam int TW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW      = $clog2(TABLE_ENTRIES + 1);
   localparam int PA_W    = $clog2(PEER_IDS);
   localparam int CLR_LEN = (TABLE_ENTRIES > PEER_IDS) ? TABLE_ENTRIES : PEER_IDS;
   localparam int CLR_W   = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
   localparam int ENTRY_W = 1 + ADDR_W + PEER_W;

   typedef logic [PA_W-1:0] peer_map_type [256];

   function automatic peer_map_type build_peer_map();
      peer_map_type m;
      for (int i = 0; i < 256; i++) begin
         m[i] = PA_W'(i % PEER_IDS);
      end
      return m;
   endfunction

   localparam peer_map_type PEER_MAP = build_peer_map();

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_GONE, S_SCAN, S_DONE, S_RESULT
   } state_type;

   state_type         state_ff;
   opcode_type        op_ff;
   logic [ADDR_W-1:0] key_ff;
   logic [PEER_W-1:0] peer_ff;
   logic [CLR_W-1:0]  clr_ff;
   logic [CW-1:0]     issue_ff;
   logic              s1_v_ff;
   logic [TW-1:0]     s1_idx_ff;
   logic              s2_v_ff, s2_valid_ff, s2_hit_ff;
   logic [TW-1:0]     s2_idx_ff;
   logic [PEER_W-1:0] s2_peer_ff;
   logic              found_ff, found_alive_ff, free_ff;
   logic [PEER_W-1:0] found_peer_ff;
   logic [TW-1:0]     free_idx_ff;
   logic [CW-1:0]     cnt_ff;

   logic              pend_ok_ff;
   logic [PEER_W-1:0] pend_peer_ff;
   status_type        pend_status_ff;
   logic [ROUTE_CNT_W-1:0] pend_count_ff;

   logic              rsp_valid_ff, rsp_ok_ff;
   logic [PEER_W-1:0] rsp_peer_ff;
   status_type        rsp_status_ff;
   logic [ROUTE_CNT_W-1:0] rsp_count_ff;

   logic               accept;
   status_type         accept_status;
   logic [31:0]        clr_ext;
   hdr_result_type     hdr;
   logic               entry_we;
   logic [TW-1:0]      entry_waddr;
   logic [ENTRY_W-1:0] entry_wdata, entry_rdata;
   logic               alive_we;
   logic [PA_W-1:0]    alive_waddr, alive_raddr;
   logic [0:0]         alive_wdata, alive_rdata;
   logic               rd_valid;
   logic [ADDR_W-1:0]  rd_key;
   logic [PEER_W-1:0]  rd_peer;
   logic               dead, purge, done_insert;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign clr_ext      = 32'(clr_ff);

   assign rd_valid = entry_rdata[ENTRY_W-1];
   assign rd_key   = entry_rdata[ENTRY_W-2:PEER_W];
   assign rd_peer  = entry_rdata[PEER_W-1:0];
   assign alive_raddr = PEER_MAP[rd_peer];
   assign dead     = !alive_rdata[0];

   assign done_insert = (state_ff == S_DONE) && (op_ff == OP_REGISTER) &&
                        !(found_ff && found_alive_ff) && free_ff;

   iprt_hdr_check u_hdr (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (accept && (req_ch.opcode == OP_PACKET)),
      .byte_data (req_ch.packet_byte),
      .byte_last (req_ch.packet_last),
      .result    (hdr)
   );

   iprt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (entry_we),
      .waddr (entry_waddr),
      .wdata (entry_wdata),
      .raddr (issue_ff[TW-1:0]),
      .rdata (entry_rdata)
   );

   iprt_ram #(.WIDTH(1), .DEPTH(PEER_IDS)) u_alive_ram (
      .clock (clock),
      .we    (alive_we),
      .waddr (alive_waddr),
      .wdata (alive_wdata),
      .raddr (alive_raddr),
      .rdata (alive_rdata)
   );

   // status an item carries when it answers without a table walk
   always_comb begin
      case (opcode_type'(req_ch.opcode))
         OP_REGISTER, OP_UNREGISTER:
            accept_status = (req_ch.peer_id == '0) ? ST_NULL_PEER : ST_DONE;
         OP_PACKET: accept_status = hdr.status;
         default:   accept_status = ST_DONE;
      endcase
   end

   // drop an entry whose peer is gone, per opcode; unregister also drops a hit held by its peer
   always_comb begin
      case (op_ff)
         OP_REGISTER, OP_LOOKUP, OP_PACKET: purge = s2_hit_ff && dead;
         OP_UNREGISTER: purge = s2_hit_ff && (dead || (s2_peer_ff == peer_ff));
         OP_PEER_GONE, OP_COUNT:            purge = s2_valid_ff && dead;
         default:                           purge = 1'b0;
      endcase
   end

   always_comb begin
      entry_we    = 1'b0;
      entry_waddr = s2_idx_ff;
      entry_wdata = '0;
      alive_we    = 1'b0;
      alive_waddr = PEER_MAP[peer_ff];
      alive_wdata = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            entry_we    = clr_ext < 32'(TABLE_ENTRIES);
            entry_waddr = clr_ff[TW-1:0];
            alive_we    = clr_ext < 32'(PEER_IDS);
            alive_waddr = clr_ff[PA_W-1:0];
         end
         S_GONE: begin
            alive_we = 1'b1;
         end
         S_SCAN: begin
            entry_we = s2_v_ff && purge;
         end
         S_DONE: begin
            entry_we    = done_insert;
            entry_waddr = free_idx_ff;
            entry_wdata = {1'b1, key_ff, peer_ff};
            alive_we    = done_insert;
            alive_wdata = 1'b1;
         end
         default: begin
            entry_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ext == 32'(CLR_LEN - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= opcode_type'(req_ch.opcode);
                  key_ff   <= (opcode_type'(req_ch.opcode) == OP_PACKET) ? hdr.dest
                                                                        : req_ch.address;
                  peer_ff  <= req_ch.peer_id;
                  issue_ff <= '0;
                  s1_v_ff  <= 1'b0;
                  s2_v_ff  <= 1'b0;
                  found_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  cnt_ff   <= '0;
                  pend_ok_ff     <= 1'b0;
                  pend_peer_ff   <= '0;
                  pend_status_ff <= accept_status;
                  pend_count_ff  <= '0;
                  case (opcode_type'(req_ch.opcode))
                     OP_REGISTER, OP_UNREGISTER: begin
                        state_ff <= (req_ch.peer_id == '0) ? S_RESULT : S_SCAN;
                     end
                     OP_LOOKUP, OP_COUNT: state_ff <= S_SCAN;
                     OP_PACKET: begin
                        if (req_ch.packet_last) begin
                           state_ff <= hdr.good ? S_SCAN : S_RESULT;
                        end
                     end
                     OP_PEER_GONE: state_ff <= S_GONE;
                     default: state_ff <= S_RESULT;
                  endcase
               end
            end
            S_GONE: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // issue one entry read per cycle, two stages behind for the check
               if (issue_ff != CW'(TABLE_ENTRIES)) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               s1_v_ff     <= (issue_ff != CW'(TABLE_ENTRIES));
               s1_idx_ff   <= issue_ff[TW-1:0];
               s2_v_ff     <= s1_v_ff;
               s2_idx_ff   <= s1_idx_ff;
               s2_valid_ff <= rd_valid;
               s2_hit_ff   <= rd_valid && (rd_key == key_ff);
               s2_peer_ff  <= rd_peer;
               if (s2_v_ff) begin
                  if (s2_hit_ff) begin
                     found_ff       <= 1'b1;
                     found_alive_ff <= !dead;
                     found_peer_ff  <= s2_peer_ff;
                  end
                  if (!free_ff && (!s2_valid_ff || (s2_hit_ff && dead))) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= s2_idx_ff;
                  end
                  if (s2_valid_ff && !dead) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
               if (issue_ff == CW'(TABLE_ENTRIES) && !s1_v_ff && !s2_v_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               case (op_ff)
                  OP_REGISTER: begin
                     if (found_ff && found_alive_ff) begin
                        pend_ok_ff     <= (found_peer_ff == peer_ff);
                        pend_status_ff <= (found_peer_ff == peer_ff) ? ST_DONE : ST_HELD;
                     end else if (!free_ff) begin
                        pend_status_ff <= ST_FULL;
                     end else begin
                        pend_ok_ff <= 1'b1;
                     end
                  end
                  OP_UNREGISTER: begin
                     if (!found_ff) begin
                        pend_status_ff <= ST_NOT_FOUND;
                     end else if (found_alive_ff && (found_peer_ff != peer_ff)) begin
                        pend_status_ff <= ST_HELD;
                     end else begin
                        pend_ok_ff <= 1'b1;
                     end
                  end
                  OP_LOOKUP, OP_PACKET: begin
                     if (found_ff && found_alive_ff) begin
                        pend_ok_ff   <= 1'b1;
                        pend_peer_ff <= found_peer_ff;
                     end else begin
                        pend_status_ff <= ST_NOT_FOUND;
                     end
                  end
                  OP_COUNT: begin
                     pend_ok_ff    <= 1'b1;
                     pend_count_ff <= ROUTE_CNT_W'(cnt_ff);
                  end
                  default: begin
                     pend_ok_ff <= 1'b1;
                  end
               endcase
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ok_ff     <= pend_ok_ff;
                  rsp_peer_ff   <= pend_peer_ff;
                  rsp_status_ff <= pend_status_ff;
                  rsp_count_ff  <= pend_count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.found_peer  = rsp_peer_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.route_count = rsp_count_ff;

   `ASSERT_NEXT(a_done_to_result, state_ff == S_DONE, state_ff == S_RESULT, "done must respond")
   `ASSERT_IMPLY(a_fail_no_peer, rsp_valid_ff && !rsp_ok_ff, rsp_peer_ff == '0, "peer on failure")
   `ASSERT_IMPLY(a_count_ok, rsp_valid_ff && rsp_count_ff != '0, rsp_ok_ff, "count without ok")
   `ASSERT_IMPLY(a_issue_range, 1'b1, issue_ff <= CW'(TABLE_ENTRIES), "scan index overrun")

endmodule
